@@ sv/hrs_pkg.sv @@
package hrs_pkg;

    localparam int WINDOW    = 32;
    localparam int WIN_SLOTS = 32;
    // Table depth; the entry index field is 6 bits wide, so at most 64 entries are reachable.
    localparam int ENTRIES   = 64;
    localparam int WORDS     = 4;
    localparam int RAM_DEPTH = ENTRIES * WORDS;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam logic [63:0] MASK0_RST = 64'd287948901175001088;
    localparam logic [63:0] MASK1_RST = 64'd562809069904068608;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_SCAN    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  entry_index;
        logic [1:0]  word_select;
        logic [63:0] word_value;
        logic [7:0]  data_byte;
    } t_in;

    typedef struct packed {
        logic       match_found;
        logic [5:0] match_index;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef logic [7:0] t_win [WIN_SLOTS];

    // One table word against its slice of the window; characters past WINDOW are ignored.
    function automatic logic word_eq(input t_win win, input logic [1:0] w,
                                     input logic [63:0] data);
        logic eq;
        int   c;
        eq = 1'b1;
        for (int k = 0; k < 8; k++) begin
            c = int'(w) * 8 + k;
            if (c < WINDOW) begin
                if (data[k*8 +: 8] != win[WIN_SLOTS - WINDOW + c]) begin
                    eq = 1'b0;
                end
            end
        end
        return eq;
    endfunction

endpackage

@@ sv/hrs_ram.sv @@
module hrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/hash_reference_scanner_unit.sv @@
// Fixed-length multi-pattern scanner.
// Input channel (i_in_valid / o_in_ready, payload i_in) carries one transaction per
// request: load a table word, scan a stream byte, or restart the stream.
// Output channel (o_out_valid / i_out_ready, payload o_out) gives one transaction per
// scanned byte: match flag and lowest matching pending entry index.
// Config channel (i_cfg_valid / o_cfg_ready) writes the four 64-bit class masks;
// it is always ready and index selects the mask.
// Loads, restarts and scans with an incomplete class run need no table sweep.
// A scan that completes a full run sweeps the table RAM, one word per cycle,
// and no new transaction is taken until the sweep is done; the single read
// port of the table RAM sets that sweep rate.
// The result is registered; visible the cycle after acceptance (short scan)
// or after the sweep.
// Reset (synchronous, active low) clears the window, the run count, the pending
// marks and restores the default masks; table contents stay undefined until loaded.
// A stalled receiver holds the result register; a new transaction is taken only
// when that register is free or being drained in the same cycle.
module hash_reference_scanner_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hrs_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hrs_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data
);

    localparam int AW = hrs_pkg::RAM_AW;

    hrs_pkg::t_state r_state, n_state;
    logic [63:0] r_mask [4];
    hrs_pkg::t_win r_win;
    logic [5:0]  r_run;
    logic [hrs_pkg::ENTRIES-1:0] r_pend;
    logic [AW:0] r_cnt;           // read issue counter, one extra bit for the end
    logic        r_dv;            // read data valid this cycle
    logic [AW-1:0] r_dad;         // address of the data arriving
    logic        r_eq;            // running compare of current entry
    logic        r_found;
    logic [5:0]  r_idx;
    logic        r_out_valid;
    hrs_pkg::t_out r_out;

    logic        in_acc;
    logic        out_free;
    logic        cls;
    logic [5:0]  run_next;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0] ram_rdata;
    logic        weq;
    logic [5:0]  d_ent;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == hrs_pkg::ST_IDLE) && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Class test indexes the mask by the top two bits of the byte.
    assign cls      = r_mask[i_in.data_byte[7:6]][i_in.data_byte[5:0]];
    assign run_next = !cls ? 6'd0 :
                      (r_run < 6'(hrs_pkg::WINDOW)) ? r_run + 6'd1 : r_run;

    assign ram_we    = in_acc && (i_in.req_type == hrs_pkg::REQ_LOAD) &&
                       ({1'b0, i_in.entry_index} < 7'(hrs_pkg::ENTRIES));
    assign ram_waddr = AW'({i_in.entry_index, i_in.word_select});

    hrs_ram #(
        .WIDTH(64),
        .DEPTH(hrs_pkg::RAM_DEPTH)
    ) u_tab (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_in.word_value),
        .i_raddr(r_cnt[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign weq   = hrs_pkg::word_eq(r_win, r_dad[1:0], ram_rdata);
    assign d_ent = 6'(r_dad[AW-1:2]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            hrs_pkg::ST_IDLE: begin
                if (in_acc && (i_in.req_type == hrs_pkg::REQ_SCAN) &&
                    (run_next == 6'(hrs_pkg::WINDOW))) begin
                    n_state = hrs_pkg::ST_SCAN;
                end
            end
            hrs_pkg::ST_SCAN: begin
                if ((r_cnt == (AW+1)'(hrs_pkg::RAM_DEPTH)) && !r_dv) begin
                    n_state = hrs_pkg::ST_DONE;
                end
            end
            hrs_pkg::ST_DONE: n_state = hrs_pkg::ST_IDLE;
            default:          n_state = hrs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hrs_pkg::ST_IDLE;
            r_mask[0]   <= hrs_pkg::MASK0_RST;
            r_mask[1]   <= hrs_pkg::MASK1_RST;
            r_mask[2]   <= '0;
            r_mask[3]   <= '0;
            r_run       <= '0;
            r_pend      <= '0;
            r_cnt       <= '0;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < hrs_pkg::WIN_SLOTS; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_mask[i_cfg_index] <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (in_acc) begin
                case (i_in.req_type)
                    hrs_pkg::REQ_LOAD: begin
                        if (ram_we && (i_in.word_select == 2'd3)) begin
                            r_pend[i_in.entry_index] <= 1'b1;
                        end
                    end
                    hrs_pkg::REQ_RESTART: begin
                        r_run  <= '0;
                        r_pend <= '0;
                        for (int i = 0; i < hrs_pkg::WIN_SLOTS; i++) begin
                            r_win[i] <= '0;
                        end
                    end
                    hrs_pkg::REQ_SCAN: begin
                        for (int i = 0; i < hrs_pkg::WIN_SLOTS - 1; i++) begin
                            r_win[i] <= r_win[i+1];
                        end
                        r_win[hrs_pkg::WIN_SLOTS-1] <= i_in.data_byte;
                        r_run <= run_next;
                        if (run_next == 6'(hrs_pkg::WINDOW)) begin
                            r_cnt   <= '0;
                            r_dv    <= 1'b0;
                            r_found <= 1'b0;
                            r_idx   <= '0;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out       <= '0;
                        end
                    end
                    default: ;
                endcase
            end

            if (r_state == hrs_pkg::ST_SCAN) begin
                r_dv  <= (r_cnt != (AW+1)'(hrs_pkg::RAM_DEPTH));
                r_dad <= r_cnt[AW-1:0];
                if (r_cnt != (AW+1)'(hrs_pkg::RAM_DEPTH)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (r_dv) begin
                    if (r_dad[1:0] == 2'd0) begin
                        r_eq <= weq;
                    end else begin
                        r_eq <= r_eq && weq;
                    end
                    if ((r_dad[1:0] == 2'd3) && r_eq && weq && r_pend[d_ent]) begin
                        r_pend[d_ent] <= 1'b0;
                        if (!r_found) begin
                            r_found <= 1'b1;
                            r_idx   <= d_ent;
                        end
                    end
                end
            end

            if (r_state == hrs_pkg::ST_DONE) begin
                r_out_valid       <= 1'b1;
                r_out.match_found <= r_found;
                r_out.match_index <= r_found ? r_idx : 6'd0;
            end
        end
    end

    // No transaction is taken while the table sweep runs.
    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != hrs_pkg::ST_IDLE) |-> !o_in_ready)
        else $error("input accepted during sweep");

    // A reported entry has lost its pending mark.
    a_reported_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hrs_pkg::ST_DONE && r_found) |=> !r_pend[r_idx])
        else $error("reported entry still pending");

    // No match reports index zero.
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.match_found) |-> (o_out.match_index == 6'd0))
        else $error("nonzero index without match");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;    // undefined request code, ignored
    localparam int         DRAIN_WAIT = 300;     // longer than one full table sweep
    localparam int         IDLE_LIMIT = 6000;    // watchdog: cycles with no transaction
    localparam int         RANDOM_PER_PHASE = 190;

    // ------------------------------------------------------------------
    // Scoreboard: predicts match results and checks the output stream
    // ------------------------------------------------------------------
    class hash_match_book;
        logic [63:0]   class_mask [4];
        logic [7:0]    window [hrs_pkg::WINDOW];
        int            run_len;
        logic [63:0]   table_words [hrs_pkg::ENTRIES][hrs_pkg::WORDS];
        bit            word_written [hrs_pkg::ENTRIES][hrs_pkg::WORDS];
        bit            pending [hrs_pkg::ENTRIES];
        hrs_pkg::t_out expected_matches [$];
        int            mismatches;

        function void reset_state();
            class_mask[0] = hrs_pkg::MASK0_RST;
            class_mask[1] = hrs_pkg::MASK1_RST;
            class_mask[2] = '0;
            class_mask[3] = '0;
            foreach (window[i]) window[i] = '0;
            run_len = 0;
            foreach (pending[i]) pending[i] = 0;
            foreach (word_written[i, j]) word_written[i][j] = 0;
            mismatches = 0;
        endfunction

        function bit is_class(logic [7:0] b);
            return class_mask[b[7:6]][b[5:0]];
        endfunction

        function bit entry_hits(int e);
            for (int c = 0; c < hrs_pkg::WINDOW; c++) begin
                if (table_words[e][c / 8][(c % 8) * 8 +: 8] != window[c]) begin
                    return 0;
                end
            end
            return 1;
        endfunction

        // Apply one accepted input transaction to the predictor.
        function void note_request(hrs_pkg::t_in r);
            hrs_pkg::t_out res;
            case (r.req_type)
                hrs_pkg::REQ_LOAD: begin
                    table_words[r.entry_index][r.word_select] = r.word_value;
                    word_written[r.entry_index][r.word_select] = 1;
                    if (r.word_select == 2'd3) begin
                        pending[r.entry_index] = 1;
                    end
                end
                hrs_pkg::REQ_RESTART: begin
                    foreach (window[i]) window[i] = '0;
                    run_len = 0;
                    foreach (pending[i]) pending[i] = 0;
                end
                hrs_pkg::REQ_SCAN: begin
                    res = '0;
                    for (int i = 0; i < hrs_pkg::WINDOW - 1; i++) window[i] = window[i + 1];
                    window[hrs_pkg::WINDOW - 1] = r.data_byte;
                    if (is_class(r.data_byte)) begin
                        if (run_len < hrs_pkg::WINDOW) run_len++;
                    end else begin
                        run_len = 0;
                    end
                    if (run_len == hrs_pkg::WINDOW) begin
                        for (int e = 0; e < hrs_pkg::ENTRIES; e++) begin
                            if (pending[e] && entry_hits(e)) begin
                                pending[e] = 0;
                                if (!res.match_found) begin
                                    res.match_found = 1'b1;
                                    res.match_index = e[5:0];
                                end
                            end
                        end
                    end
                    expected_matches = {expected_matches, res};
                end
                default: ;
            endcase
        endfunction

        function void check_match(hrs_pkg::t_out got);
            hrs_pkg::t_out want;
            if (expected_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0d index=%0d",
                             got.match_found, got.match_index);
                return;
            end
            want = expected_matches.pop_front();
            if (got.match_found !== want.match_found || got.match_index !== want.match_index) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected found=%0d index=%0d, got found=%0d index=%0d",
                             want.match_found, want.match_index,
                             got.match_found, got.match_index);
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    hrs_pkg::t_in  i_in;
    logic          o_out_valid;
    logic          i_out_ready;
    hrs_pkg::t_out o_out;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index;
    logic [63:0]   i_cfg_data;

    hash_match_book book;
    int             idle_cycles;
    int             burst_left;
    int             n_sent;
    logic [7:0]     str [hrs_pkg::WINDOW];

    hash_reference_scanner_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
    end

    always #5 i_clk = ~i_clk;

    // Result side: check every output transaction; the receiver's ready follows a random
    // mode (always ready, coin flip, mostly stalled) redrawn whenever its counter runs out.
    int ready_mode;
    int mode_cycles;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            book.check_match(o_out);
        end
        if (mode_cycles == 0) begin
            ready_mode  <= $urandom_range(0, 2);
            mode_cycles <= 200;
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        case (ready_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog: counts cycles with no transaction on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one request transaction; the sender works in bursts with random gaps.
    task automatic send_req(input hrs_pkg::t_in r);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= r;
        do @(posedge i_clk); while (!o_in_ready);
        book.note_request(r);
        n_sent++;
    endtask

    task automatic go_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every predicted result arrived, then let a table sweep finish.
    task automatic drain();
        go_quiet();
        while (book.expected_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_mask(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.class_mask[idx] = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_word(input int e, input int w, input logic [63:0] v);
        hrs_pkg::t_in r;
        r             = hrs_pkg::t_in'({$urandom, $urandom, $urandom});
        r.req_type    = hrs_pkg::REQ_LOAD;
        r.entry_index = e[5:0];
        r.word_select = w[1:0];
        r.word_value  = v;
        send_req(r);
    endtask

    task automatic scan_byte(input logic [7:0] b);
        hrs_pkg::t_in r;
        r           = hrs_pkg::t_in'({$urandom, $urandom, $urandom});
        r.req_type  = hrs_pkg::REQ_SCAN;
        r.data_byte = b;
        send_req(r);
    endtask

    task automatic send_code(input logic [1:0] code);
        hrs_pkg::t_in r;
        r          = hrs_pkg::t_in'({$urandom, $urandom, $urandom});
        r.req_type = code;
        send_req(r);
    endtask

    // Random byte inside the current class; random byte if the class is empty.
    function automatic logic [7:0] class_byte();
        logic [7:0] b;
        b = 8'($urandom);
        for (int i = 0; i < 256; i++) begin
            if (book.is_class(b)) return b;
            b = (i < 32) ? 8'($urandom) : b + 8'd1;
        end
        return b;
    endfunction

    function automatic logic [7:0] other_byte();
        logic [7:0] b;
        b = 8'($urandom);
        for (int i = 0; i < 256; i++) begin
            if (!book.is_class(b)) return b;
            b = b + 8'd1;
        end
        return b;
    endfunction

    // Fill str with class bytes and load it into entry e, word 3 last.
    task automatic load_string(input int e);
        logic [63:0] w;
        foreach (str[i]) str[i] = class_byte();
        for (int k = 0; k < hrs_pkg::WORDS; k++) begin
            for (int j = 0; j < 8; j++) w[j*8 +: 8] = str[k*8 + j];
            load_word(e, k, w);
        end
    endtask

    task automatic scan_string();
        foreach (str[i]) scan_byte(str[i]);
    endtask

    // Copy a fully written entry back into str.
    function automatic void entry_string(input int e);
        for (int c = 0; c < hrs_pkg::WINDOW; c++)
            str[c] = book.table_words[e][c / 8][(c % 8) * 8 +: 8];
    endfunction

    function automatic bit entry_full(input int e);
        return book.word_written[e][0] && book.word_written[e][1]
            && book.word_written[e][2] && book.word_written[e][3];
    endfunction

    // One random phase: load-then-scan sequences with random content, plus noise,
    // restarts, unused codes, reloads, partial loads and broken sequences.
    task automatic random_phase(input int n_items);
        int start;
        int e;
        int pick;
        start = n_sent;
        while (n_sent - start < n_items) begin
            pick = $urandom_range(0, 99);
            e    = $urandom_range(0, hrs_pkg::ENTRIES - 1);
            if (pick < 40) begin
                load_string(e);
                repeat ($urandom_range(0, 6))
                    scan_byte($urandom_range(0, 1) ? class_byte() : 8'($urandom));
                scan_string();
                // saturated run keeps comparing; a repeat must not report again
                if ($urandom_range(0, 2) == 0) scan_string();
            end else if (pick < 55) begin
                // reload word 3 of a complete entry and scan it again
                if (entry_full(e)) begin
                    entry_string(e);
                    load_word(e, 3, book.table_words[e][3]);
                    scan_string();
                end
            end else if (pick < 65) begin
                // broken string: a non-class byte inside the run
                load_string(e);
                str[$urandom_range(0, hrs_pkg::WINDOW - 1)] = other_byte();
                scan_string();
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 8)) scan_byte(8'($urandom));
            end else if (pick < 90) begin
                send_code(hrs_pkg::REQ_RESTART);
            end else if (pick < 94) begin
                send_code(REQ_UNUSED);
            end else begin
                // partial word loads; word 3 only once the others exist
                pick = $urandom_range(0, 3);
                if (pick != 3 || (book.word_written[e][0] && book.word_written[e][1]
                                  && book.word_written[e][2])) begin
                    load_word(e, pick, {$urandom, $urandom});
                end
            end
        end
    endtask

    initial begin
        book        = new();
        book.reset_state();
        burst_left  = 0;
        n_sent      = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: duplicate entries at both ends of the table, unused code,
        // a non-class byte, a full hit, a repeat (no second report), restart.
        load_string(0);
        for (int k = 0; k < hrs_pkg::WORDS; k++)
            load_word(hrs_pkg::ENTRIES - 1, k, book.table_words[0][k]);
        send_code(REQ_UNUSED);
        scan_byte(8'hFF);
        scan_byte(8'h00);
        scan_string();
        scan_string();
        load_word(5, 0, 64'h0);
        load_word(5, 1, 64'hFFFF_FFFF_FFFF_FFFF);
        load_word(5, 2, 64'h0);
        load_word(5, 3, 64'hFFFF_FFFF_FFFF_FFFF);
        send_code(hrs_pkg::REQ_RESTART);
        scan_string();

        // Random phases under several mask settings; masks written only when idle.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_mask(2'd0, hrs_pkg::MASK0_RST);
                    write_mask(2'd1, hrs_pkg::MASK1_RST);
                    write_mask(2'd2, '0);
                    write_mask(2'd3, '0);
                end
                1: for (int k = 0; k < 4; k++) write_mask(k[1:0], '1);
                2: begin
                    for (int k = 0; k < 3; k++) write_mask(k[1:0], '0);
                    write_mask(2'd3, '1);
                end
                3: for (int k = 0; k < 4; k++) write_mask(k[1:0], '0);
                default: for (int k = 0; k < 4; k++) write_mask(k[1:0], {$urandom, $urandom});
            endcase
            random_phase(RANDOM_PER_PHASE);
        end

        drain();
        if (book.mismatches == 0 && book.expected_matches.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
